// ===== hw/rtl/kcl_pkg.sv =====
package kcl_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam int unsigned NumCols   = 3;
  localparam int unsigned NumDigits = 4;
  localparam int unsigned HistDepth = 9;

  localparam logic [3:0] KeyStar    = 4'd10;
  localparam logic [3:0] KeyHash    = 4'd11;
  localparam logic [3:0] KeyNone    = 4'd15;
  localparam logic [3:0] DigitEmpty = 4'd14;
  localparam logic [3:0] DispAccept = 4'd11;
  localparam logic [3:0] DispReject = 4'd12;

  localparam logic [1:0] StageOne   = 2'd0;
  localparam logic [1:0] StageTwo   = 2'd1;
  localparam logic [1:0] StageThree = 2'd2;

  localparam logic [1:0] ColOne   = 2'd0;
  localparam logic [1:0] ColTwo   = 2'd1;
  localparam logic [1:0] ColThree = 2'd2;

  typedef enum logic [2:0] {
    PhIdle,
    PhStart,
    PhNum1,
    PhNum2,
    PhNum3,
    PhNum4
  } phase_e;

  typedef struct packed {
    logic [1:0] stage;
    phase_e     phase;
    logic [3:0] key;
    logic [2:0] col_drive;
  } item_t;

  function automatic logic [3:0] sample_key(logic [1:0] col, logic [3:0] rows);
    logic [3:0] k;
    k = KeyNone;
    unique case (col)
      ColOne: begin
        unique case (rows)
          4'b0001: k = 4'd1;
          4'b0010: k = 4'd4;
          4'b0100: k = 4'd7;
          4'b1000: k = KeyStar;
          default: k = KeyNone;
        endcase
      end
      ColTwo: begin
        unique case (rows)
          4'b0001: k = 4'd2;
          4'b0010: k = 4'd5;
          4'b0100: k = 4'd8;
          4'b1000: k = 4'd0;
          default: k = KeyNone;
        endcase
      end
      default: begin
        unique case (rows)
          4'b0001: k = 4'd3;
          4'b0010: k = 4'd6;
          4'b0100: k = 4'd9;
          4'b1000: k = KeyHash;
          default: k = KeyNone;
        endcase
      end
    endcase
    return k;
  endfunction

endpackage

// ===== hw/rtl/keypad_code_lock.sv =====
// Keypad scanner and four-digit code lock. Each item is one scan tick: the
// row lines sampled under the current column and the current authorization
// stage; each item yields exactly one result with the column to drive next,
// the debounced key, an optional display code and the updated stage. The
// front end decodes keys, runs the debounce history, column sequence and
// entry phase; a short queue hands each item to the back end, which keeps
// the entered digits, compares on '#' and registers the result. One item is
// taken per clock while the output is ready; it is queued, then registered.
// The queue holds QueueDepth items while the output stalls. The user must
// write code digits through the cfg port while idle; this is not enforced.
module keypad_code_lock #(
  parameter int unsigned QueueDepth = kcl_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [3:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [3:0] row_lines_i,
  input  logic [1:0] auth_stage_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] column_drive_o,
  output logic [3:0] key_seen_o,
  output logic       display_valid_o,
  output logic [3:0] display_code_o,
  output logic [1:0] auth_stage_out_o
);

  logic [3:0][3:0] code_q;
  logic            push_valid, push_ready, pop_valid, pop_ready;
  kcl_pkg::item_t  push_item, pop_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= '0;
    end else if (cfg_we_i) begin
      code_q[cfg_index_i] <= cfg_data_i;
    end
  end

  kcl_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .row_lines_i    (row_lines_i),
    .auth_stage_in_i(auth_stage_in_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_item_o    (push_item)
  );

  kcl_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_item_i (push_item),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_item_o  (pop_item)
  );

  kcl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .code_i          (code_q),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .item_i          (pop_item),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .column_drive_o  (column_drive_o),
    .key_seen_o      (key_seen_o),
    .display_valid_o (display_valid_o),
    .display_code_o  (display_code_o),
    .auth_stage_out_o(auth_stage_out_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(column_drive_o))
    else $error("column drive not one-hot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !display_valid_o |-> display_code_o == 4'd0)
    else $error("display code set without display valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && display_valid_o && display_code_o == kcl_pkg::DispAccept
      |-> key_seen_o == kcl_pkg::KeyHash && column_drive_o == 3'b001)
    else $error("accept shown without a submit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("queue full while output is empty");

endmodule

// ===== hw/rtl/kcl_front.sv =====
module kcl_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [3:0]     row_lines_i,
  input  logic [1:0]     auth_stage_in_i,
  output logic           push_valid_o,
  input  logic           push_ready_i,
  output kcl_pkg::item_t push_item_o
);

  logic [1:0]      col_q, col_d;
  logic [3:0]      hist_q [kcl_pkg::HistDepth];
  kcl_pkg::phase_e phase_q, phase_d;
  logic [3:0]      raw;
  logic [3:0]      key;
  logic            qual;
  logic            active;
  logic            accept;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  assign raw    = kcl_pkg::sample_key(col_q, row_lines_i);
  assign qual   = (raw == hist_q[2]) && (hist_q[5] == kcl_pkg::KeyNone) &&
                  (hist_q[8] == kcl_pkg::KeyNone);
  assign key    = qual ? raw : kcl_pkg::KeyNone;
  assign active = (phase_q >= kcl_pkg::PhStart) && (phase_q <= kcl_pkg::PhNum4);

  always_comb begin
    col_d   = (col_q >= kcl_pkg::ColThree) ? kcl_pkg::ColOne : col_q + 2'd1;
    phase_d = phase_q;
    if (active) begin
      if (key == kcl_pkg::KeyStar) begin
        phase_d = kcl_pkg::PhStart;
      end else if (key == kcl_pkg::KeyHash) begin
        phase_d = kcl_pkg::PhIdle;
        col_d   = kcl_pkg::ColOne;
      end else if (key != kcl_pkg::KeyNone && phase_q < kcl_pkg::PhNum4) begin
        phase_d = kcl_pkg::phase_e'(phase_q + 3'd1);
      end
    end else if (phase_q == kcl_pkg::PhIdle && key == kcl_pkg::KeyStar) begin
      phase_d = kcl_pkg::PhStart;
    end
  end

  always_comb begin
    push_item_o.stage     = auth_stage_in_i;
    push_item_o.phase     = phase_q;
    push_item_o.key       = key;
    push_item_o.col_drive = 3'b001 << col_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= kcl_pkg::ColOne;
      phase_q <= kcl_pkg::PhIdle;
      for (int i = 0; i < kcl_pkg::HistDepth; i++) begin
        hist_q[i] <= kcl_pkg::KeyNone;
      end
    end else if (accept) begin
      col_q     <= col_d;
      phase_q   <= phase_d;
      hist_q[0] <= raw;
      for (int i = 1; i < kcl_pkg::HistDepth; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

endmodule

// ===== hw/rtl/kcl_queue.sv =====
module kcl_queue #(
  parameter int unsigned Depth = kcl_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  kcl_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output kcl_pkg::item_t pop_item_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  kcl_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/kcl_back.sv =====
module kcl_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [3:0][3:0]      code_i,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  kcl_pkg::item_t       item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           column_drive_o,
  output logic [3:0]           key_seen_o,
  output logic                 display_valid_o,
  output logic [3:0]           display_code_o,
  output logic [1:0]           auth_stage_out_o
);

  logic [3:0][3:0] digits_q, digits_d;
  logic [3:0][3:0] eff;
  logic            out_valid_q;
  logic [2:0]      col_q;
  logic [3:0]      key_q, dcode_q, dcode;
  logic            disp_q, disp;
  logic [1:0]      stage_q, stage;
  logic            active, match, take;
  logic [1:0]      slot;

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign take        = pop_valid_i && pop_ready_o;

  assign active = (item_i.phase >= kcl_pkg::PhStart) && (item_i.phase <= kcl_pkg::PhNum4);
  assign eff    = (item_i.phase == kcl_pkg::PhStart) ? {4{kcl_pkg::DigitEmpty}} : digits_q;
  assign match  = (eff == code_i);
  assign slot   = 2'(item_i.phase - 3'(kcl_pkg::PhStart));

  always_comb begin
    digits_d = eff;
    stage    = item_i.stage;
    disp     = 1'b0;
    dcode    = '0;
    if (active) begin
      if (item_i.key == kcl_pkg::KeyStar) begin
        disp  = 1'b1;
        dcode = kcl_pkg::KeyStar;
      end else if (item_i.key == kcl_pkg::KeyHash) begin
        if (match && item_i.stage == kcl_pkg::StageOne) begin
          stage = kcl_pkg::StageTwo;
        end else if (match && item_i.stage == kcl_pkg::StageThree) begin
          stage = kcl_pkg::StageOne;
        end
      end else if (item_i.key != kcl_pkg::KeyNone && item_i.phase < kcl_pkg::PhNum4) begin
        digits_d[slot] = item_i.key;
        disp  = 1'b1;
        dcode = item_i.key;
      end
    end else if (item_i.phase == kcl_pkg::PhIdle && item_i.key == kcl_pkg::KeyStar) begin
      disp  = 1'b1;
      dcode = kcl_pkg::KeyStar;
    end
    if (item_i.key == kcl_pkg::KeyHash) begin
      disp  = 1'b1;
      dcode = (stage != item_i.stage) ? kcl_pkg::DispAccept : kcl_pkg::DispReject;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      digits_q    <= {4{kcl_pkg::DigitEmpty}};
    end else begin
      if (take) begin
        out_valid_q <= 1'b1;
        digits_q    <= digits_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      col_q   <= item_i.col_drive;
      key_q   <= item_i.key;
      disp_q  <= disp;
      dcode_q <= dcode;
      stage_q <= stage;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign column_drive_o   = col_q;
  assign key_seen_o       = key_q;
  assign display_valid_o  = disp_q;
  assign display_code_o   = dcode_q;
  assign auth_stage_out_o = stage_q;

endmodule

// ===== bench/keypad_code_lock_checker.sv =====
`timescale 1ns / 100ps

module keypad_code_lock_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [3:0]        cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [3:0]        row_lines_i,
  input  logic [1:0]        auth_stage_in_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [2:0]        column_drive_i,
  input  logic [3:0]        key_seen_i,
  input  logic              display_valid_i,
  input  logic [3:0]        display_code_i,
  input  logic [1:0]        auth_stage_out_i,
  output int unsigned       failures_o,
  output int unsigned       pending_o
);
  import kcl_pkg::*;

  typedef struct packed {
    logic [2:0] column_drive;
    logic [3:0] key_seen;
    logic       display_valid;
    logic [3:0] display_code;
    logic [1:0] auth_stage;
  } scan_result_t;

  // column-major: entry col*4 + row, top row first
  localparam logic [11:0][3:0] PadLayout = {
    KeyHash, 4'd9, 4'd6, 4'd3,
    4'd0,    4'd8, 4'd5, 4'd2,
    KeyStar, 4'd7, 4'd4, 4'd1
  };

  logic [1:0]   scan_col;
  logic [3:0]   raw_hist [HistDepth];
  phase_e       entry_step;
  logic [3:0]   typed_digits [NumDigits];
  logic [3:0]   lock_code [NumDigits];
  scan_result_t expected_scans [$];
  scan_result_t predicted, head;

  task automatic predict_scan(input logic [3:0] rows, input logic [1:0] stage_in,
                              output scan_result_t res);
    logic [3:0] raw, key, shown;
    logic [1:0] stage, col;
    logic       shown_valid, qualified, match;
    logic [1:0] slot;
    col = (scan_col > ColThree) ? ColThree : scan_col;
    raw = KeyNone;
    for (int r = 0; r < 4; r++) begin
      if (rows == (4'b0001 << r)) raw = PadLayout[col * 4 + r];
    end
    scan_col = (scan_col >= ColThree) ? ColOne : scan_col + 2'd1;
    qualified = (raw == raw_hist[2]) && (raw_hist[5] == KeyNone) &&
                (raw_hist[8] == KeyNone);
    for (int i = HistDepth - 1; i > 0; i--) raw_hist[i] = raw_hist[i - 1];
    raw_hist[0] = raw;
    key = qualified ? raw : KeyNone;
    stage = stage_in;
    shown_valid = 1'b0;
    shown = 4'd0;
    if (entry_step == PhStart) begin
      for (int i = 0; i < NumDigits; i++) typed_digits[i] = DigitEmpty;
    end
    if (entry_step >= PhStart && entry_step <= PhNum4) begin
      if (key == KeyStar) begin
        entry_step = PhStart;
        shown_valid = 1'b1;
        shown = KeyStar;
      end else if (key == KeyHash) begin
        match = 1'b1;
        for (int i = 0; i < NumDigits; i++) begin
          if (lock_code[i] != typed_digits[i]) match = 1'b0;
        end
        entry_step = PhIdle;
        scan_col = ColOne;
        if (match && stage == StageOne) stage = StageTwo;
        else if (match && stage == StageThree) stage = StageOne;
      end else if (key != KeyNone && entry_step != PhNum4) begin
        slot = 2'(entry_step - 3'(PhStart));
        typed_digits[slot] = key;
        entry_step = phase_e'(entry_step + 3'd1);
        shown_valid = 1'b1;
        shown = key;
      end
    end else if (entry_step == PhIdle && key == KeyStar) begin
      entry_step = PhStart;
      shown_valid = 1'b1;
      shown = KeyStar;
    end
    if (key == KeyHash) begin
      shown_valid = 1'b1;
      shown = (stage != stage_in) ? DispAccept : DispReject;
    end
    res.column_drive  = 3'b001 << scan_col;
    res.key_seen      = key;
    res.display_valid = shown_valid;
    res.display_code  = shown_valid ? shown : 4'd0;
    res.auth_stage    = stage;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_col = ColOne;
      entry_step = PhIdle;
      for (int i = 0; i < HistDepth; i++) raw_hist[i] = KeyNone;
      for (int i = 0; i < NumDigits; i++) begin
        typed_digits[i] = DigitEmpty;
        lock_code[i] = 4'd0;
      end
      expected_scans.delete();
      failures_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) lock_code[cfg_index_i] = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_scans.size() == 0) begin
          $error("result item with nothing expected");
          failures_o++;
        end else begin
          head = expected_scans.pop_front();
          if (column_drive_i !== head.column_drive) begin
            $error("column_drive: expected %0d, got %0d", head.column_drive, column_drive_i);
            failures_o++;
          end
          if (key_seen_i !== head.key_seen) begin
            $error("key_seen: expected %0d, got %0d", head.key_seen, key_seen_i);
            failures_o++;
          end
          if (display_valid_i !== head.display_valid) begin
            $error("display_valid: expected %0d, got %0d", head.display_valid,
                   display_valid_i);
            failures_o++;
          end
          if (display_code_i !== head.display_code) begin
            $error("display_code: expected %0d, got %0d", head.display_code, display_code_i);
            failures_o++;
          end
          if (auth_stage_out_i !== head.auth_stage) begin
            $error("auth_stage_out: expected %0d, got %0d", head.auth_stage,
                   auth_stage_out_i);
            failures_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_scan(row_lines_i, auth_stage_in_i, predicted);
        expected_scans.push_back(predicted);
      end
      pending_o = expected_scans.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import kcl_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned PhaseItems = 400;
  localparam int unsigned NumPhases  = 5;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainWait  = 4;
  localparam logic [3:0]  MaxDigit   = 4'd9;
  localparam logic [1:0]  RegCodeDigit0 = 2'd0;

  localparam logic [11:0][3:0] PadLayout = {
    KeyHash, 4'd9, 4'd6, 4'd3,
    4'd0,    4'd8, 4'd5, 4'd2,
    KeyStar, 4'd7, 4'd4, 4'd1
  };

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [3:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [3:0] row_lines_i;
  logic [1:0] auth_stage_in_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [2:0] column_drive_o;
  logic [3:0] key_seen_o;
  logic       display_valid_o;
  logic [3:0] display_code_o;
  logic [1:0] auth_stage_out_o;

  int unsigned failures, pending;
  int unsigned tick_count, stall_cycles;
  logic        calm, sink_hold, sink_hold_req;
  logic [1:0]  col_track;
  logic [3:0]  track_hist [HistDepth];
  logic        entry_open;
  logic [3:0]  code_now [NumDigits];

  keypad_code_lock uut (.*);

  keypad_code_lock_checker lock_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .row_lines_i     (row_lines_i),
    .auth_stage_in_i (auth_stage_in_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .column_drive_i  (column_drive_o),
    .key_seen_i      (key_seen_o),
    .display_valid_i (display_valid_o),
    .display_code_i  (display_code_o),
    .auth_stage_out_i(auth_stage_out_o),
    .failures_o      (failures),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= !sink_hold && (calm || $urandom_range(0, 99) >= 25);
    end
  end

  // hold the output side off long enough for the block to fill and stall
  initial begin
    sink_hold = 1'b0;
    wait (sink_hold_req === 1'b1);
    sink_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("[keypad_code_lock] ERROR");
    $finish;
  end

  // one scan tick; mirrors column and entry tracking so presses land on the right column
  task automatic drive_tick(input logic [3:0] rows, input logic [1:0] stage,
                            output logic [3:0] got_key);
    logic [3:0] raw;
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    row_lines_i <= rows;
    auth_stage_in_i <= stage;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    raw = KeyNone;
    for (int r = 0; r < 4; r++) begin
      if (rows == (4'b0001 << r)) raw = PadLayout[col_track * 4 + r];
    end
    got_key = (raw == track_hist[2] && track_hist[5] == KeyNone &&
               track_hist[8] == KeyNone) ? raw : KeyNone;
    for (int i = HistDepth - 1; i > 0; i--) track_hist[i] = track_hist[i - 1];
    track_hist[0] = raw;
    col_track = (col_track == ColThree) ? ColOne : col_track + 2'd1;
    if (got_key == KeyStar) begin
      entry_open = 1'b1;
    end else if (got_key == KeyHash && entry_open) begin
      entry_open = 1'b0;
      col_track = ColOne;
    end
    tick_count++;
    @(negedge clk_i);
  endtask

  task automatic press_key(input logic [3:0] key, input logic [1:0] stage);
    int         slot;
    logic [3:0] got, lines;
    slot = 0;
    for (int s = 0; s < 12; s++) begin
      if (PadLayout[s] == key) slot = s;
    end
    // release: quiet or multi-row lines long enough to clear the debounce window
    repeat ($urandom_range(6, 9)) begin
      lines = 4'($urandom_range(0, 15));
      if ((lines & (lines - 4'd1)) == 4'd0) lines = 4'd0;
      drive_tick(lines, stage, got);
    end
    got = KeyNone;
    while (got != key)
      drive_tick((col_track == slot / 4) ? 4'd1 << (slot % 4) : 4'd0, stage, got);
    repeat ($urandom_range(0, 3))
      drive_tick((col_track == slot / 4) ? 4'd1 << (slot % 4) : 4'd0, stage, got);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_code(input logic [3:0] d0, input logic [3:0] d1,
                            input logic [3:0] d2, input logic [3:0] d3);
    code_now[0] = d0;
    code_now[1] = d1;
    code_now[2] = d2;
    code_now[3] = d3;
    for (int i = 0; i < NumDigits; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= RegCodeDigit0 + i[1:0];
      cfg_data_i <= code_now[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [3:0]  got, d;
    logic [1:0]  stage;
    int unsigned pick, n, phase_end;
    logic        exact;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    row_lines_i = '0;
    auth_stage_in_i = '0;
    calm = 1'b0;
    sink_hold_req = 1'b0;
    col_track = ColOne;
    entry_open = 1'b0;
    tick_count = 0;
    for (int i = 0; i < HistDepth; i++) track_hist[i] = KeyNone;
    for (int i = 0; i < NumDigits; i++) code_now[i] = 4'd0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_code(4'd1, 4'd2, 4'd3, 4'd4);
    for (int r = 0; r < 16; r++) drive_tick(r[3:0], r[1:0], got);
    press_key(KeyHash, StageOne);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      case (ph)
        0: write_code(4'd0, 4'd0, 4'd0, 4'd0);
        1: write_code(MaxDigit, MaxDigit, MaxDigit, MaxDigit);
        4: begin
          d = 4'($urandom_range(0, 9));
          write_code(d, 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)), DigitEmpty);
        end
        default: write_code(4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                            4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)));
      endcase
      calm = (ph == 2);
      if (ph == 3) sink_hold_req = 1'b1;
      phase_end = tick_count + PhaseItems;
      while (tick_count < phase_end) begin
        pick = $urandom_range(0, 99);
        stage = 2'($urandom_range(0, 3));
        if (pick < 70) begin
          press_key(KeyStar, stage);
          exact = 1'($urandom_range(0, 1));
          if (exact) begin
            n = 0;
            while (n < NumDigits && code_now[n] <= MaxDigit) n++;
          end else begin
            n = ($urandom_range(0, 3) != 0) ? NumDigits : $urandom_range(0, 6);
          end
          for (int i = 0; i < n; i++)
            press_key(exact ? code_now[i] : 4'($urandom_range(0, 9)), stage);
          press_key(KeyHash, stage);
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 8))
            drive_tick(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)), got);
        end else begin
          repeat ($urandom_range(1, 4)) press_key(4'($urandom_range(0, 11)), stage);
        end
      end
    end
    calm = 1'b0;

    drain();
    repeat (10) @(negedge clk_i);
    if (failures == 0 && pending == 0)
      $display("[keypad_code_lock] OK");
    else
      $display("[keypad_code_lock] ERROR");
    $finish;
  end

endmodule
